// ===== design/tlif_pkg.sv =====
`default_nettype none

package tlif_pkg;

  // default line buffer size
  localparam int MAX_LINE_DEF = 64;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int ECHO_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;
  localparam int IAC_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SPACE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_ECHO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IAC_CHECK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_BOT     = 3'd4;

  // line capacity after reset
  localparam logic [CFG_DATA_W-1:0] MAX_CHARS_RST = 7'd16;

  // echo codes
  localparam logic [ECHO_W-1:0] ECHO_NONE  = 3'd0;
  localparam logic [ECHO_W-1:0] ECHO_CHAR  = 3'd1;
  localparam logic [ECHO_W-1:0] ECHO_STAR  = 3'd2;
  localparam logic [ECHO_W-1:0] ECHO_ERASE = 3'd3;
  localparam logic [ECHO_W-1:0] ECHO_CLEAR = 3'd4;

  // line status codes
  localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TERM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

  // special bytes
  localparam logic [BYTE_W-1:0] B_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] B_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] B_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] B_KILL  = 8'h15;
  localparam logic [BYTE_W-1:0] B_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] B_UNDER = 8'h5f;
  localparam logic [BYTE_W-1:0] B_DEL   = 8'h7f;
  localparam logic [BYTE_W-1:0] B_SE    = 8'hf0;
  localparam logic [BYTE_W-1:0] B_SB    = 8'hfa;
  localparam logic [BYTE_W-1:0] B_DONT  = 8'hfe;
  localparam logic [BYTE_W-1:0] B_IAC   = 8'hff;

  // telnet receive phase, one-hot
  typedef enum logic [4:0] {
    PH_NORMAL   = 5'b00001,
    PH_IAC      = 5'b00010,
    PH_OPTION   = 5'b00100,
    PH_SUBNEG   = 5'b01000,
    PH_AFTER_CR = 5'b10000
  } phase_t;

  // single-bit mode settings
  typedef struct packed {
    logic flip_space;
    logic shadow_echo;
    logic min_iac_check;
    logic known_bot;
  } mode_t;

  // one result item
  typedef struct packed {
    logic [ECHO_W-1:0]   echo_kind;
    logic                store_valid;
    logic [INDEX_W-1:0]  store_index;
    logic [BYTE_W-1:0]   store_char;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    final_length;
    logic                bot_suspect;
  } res_t;

  // letters, digits, underscore and space
  function automatic logic is_line_char(input logic [BYTE_W-1:0] b);
    logic lower, upper, digit;
    lower = (b >= 8'h61) && (b <= 8'h7a);
    upper = (b >= 8'h41) && (b <= 8'h5a);
    digit = (b >= 8'h30) && (b <= 8'h39);
    return lower || upper || digit || (b == B_UNDER) || (b == B_SPACE);
  endfunction

endpackage

`default_nettype wire

// ===== design/tlif_cfg.sv =====
`default_nettype none

module tlif_cfg #(
  parameter int MAX_LINE = tlif_pkg::MAX_LINE_DEF,
  localparam int CNT_W = $clog2(MAX_LINE + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [tlif_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire logic [tlif_pkg::CFG_DATA_W-1:0]     wr_data,
  output tlif_pkg::mode_t                          mode,
  output logic [CNT_W-1:0]                         cap
);

  localparam logic [7:0] ML8 = 8'(MAX_LINE);

  logic [7:0]       rst_mc8;
  logic [7:0]       rst_cap8;
  logic [7:0]       wr_mc8;
  logic [7:0]       wr_cap8;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_nxt;
  tlif_pkg::mode_t  mode_r;
  tlif_pkg::mode_t  mode_nxt;

  // capacity is held already clamped to 1..MAX_LINE
  always_comb begin
    rst_mc8  = {1'b0, tlif_pkg::MAX_CHARS_RST};
    rst_cap8 = (rst_mc8 > ML8) ? ML8 : rst_mc8;
    wr_mc8   = {1'b0, wr_data};
    if (wr_mc8 == 8'd0) begin
      wr_cap8 = 8'd1;
    end else if (wr_mc8 > ML8) begin
      wr_cap8 = ML8;
    end else begin
      wr_cap8 = wr_mc8;
    end
  end

  // register write decode
  always_comb begin
    cap_nxt  = cap_r;
    mode_nxt = mode_r;
    if (wr_en) begin
      unique case (wr_index)
        tlif_pkg::CFG_MAX_CHARS:     cap_nxt = CNT_W'(wr_cap8);
        tlif_pkg::CFG_FLIP_SPACE:    mode_nxt.flip_space = wr_data[0];
        tlif_pkg::CFG_SHADOW_ECHO:   mode_nxt.shadow_echo = wr_data[0];
        tlif_pkg::CFG_MIN_IAC_CHECK: mode_nxt.min_iac_check = wr_data[0];
        tlif_pkg::CFG_KNOWN_BOT:     mode_nxt.known_bot = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r                <= CNT_W'(rst_cap8);
      mode_r.flip_space    <= 1'b1;
      mode_r.shadow_echo   <= 1'b0;
      mode_r.min_iac_check <= 1'b0;
      mode_r.known_bot     <= 1'b0;
    end else begin
      cap_r  <= cap_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign cap  = cap_r;
  assign mode = mode_r;

endmodule

`default_nettype wire

// ===== design/tlif_core.sv =====
`default_nettype none

module tlif_core #(
  parameter int MAX_LINE = tlif_pkg::MAX_LINE_DEF,
  localparam int CNT_W = $clog2(MAX_LINE + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             fire,
  input  wire logic [tlif_pkg::BYTE_W-1:0]      in_byte,
  input  wire tlif_pkg::mode_t                  mode,
  input  wire logic [CNT_W-1:0]                 cap,
  output tlif_pkg::res_t                        res
);

  tlif_pkg::phase_t          phase_r;
  tlif_pkg::phase_t          phase_nxt;
  logic [CNT_W-1:0]          char_count_r;
  logic [CNT_W-1:0]          char_count_nxt;
  logic [tlif_pkg::IAC_W-1:0] iac_count_r;
  logic [tlif_pkg::IAC_W-1:0] iac_count_nxt;
  logic                      finish;
  logic [tlif_pkg::STATUS_W-1:0] fin_status;
  logic [7:0]                cnt8;
  logic [7:0]                len8;

  // decode one byte against the current phase and line state
  always_comb begin
    res            = '0;
    phase_nxt      = phase_r;
    char_count_nxt = char_count_r;
    iac_count_nxt  = iac_count_r;
    finish         = 1'b0;
    fin_status     = tlif_pkg::ST_BUSY;
    cnt8           = 8'(char_count_r);
    len8           = 8'd0;

    unique case (phase_r)
      tlif_pkg::PH_IAC: begin
        if ((in_byte < tlif_pkg::B_SB) || (in_byte > tlif_pkg::B_DONT)) begin
          finish     = 1'b1;
          fin_status = tlif_pkg::ST_REJECT;
        end else if (in_byte == tlif_pkg::B_SB) begin
          phase_nxt = tlif_pkg::PH_SUBNEG;
        end else begin
          phase_nxt = tlif_pkg::PH_OPTION;
        end
      end
      tlif_pkg::PH_OPTION: begin
        phase_nxt = tlif_pkg::PH_NORMAL;
      end
      tlif_pkg::PH_SUBNEG: begin
        if (in_byte == tlif_pkg::B_SE) begin
          phase_nxt = tlif_pkg::PH_NORMAL;
        end
      end
      tlif_pkg::PH_AFTER_CR: begin
        finish     = 1'b1;
        fin_status = tlif_pkg::ST_TERM;
      end
      tlif_pkg::PH_NORMAL: begin
        // line already at capacity (capacity lowered mid-line)
        if (char_count_r >= cap) begin
          finish     = 1'b1;
          fin_status = tlif_pkg::ST_FULL;
        end else if (tlif_pkg::is_line_char(in_byte)) begin
          res.echo_kind   = mode.shadow_echo ? tlif_pkg::ECHO_STAR : tlif_pkg::ECHO_CHAR;
          res.store_valid = 1'b1;
          res.store_index = cnt8[tlif_pkg::INDEX_W-1:0];
          res.store_char  = (mode.flip_space && (in_byte == tlif_pkg::B_SPACE)) ?
                            tlif_pkg::B_UNDER : in_byte;
          char_count_nxt  = char_count_r + 1'b1;
          if (char_count_nxt >= cap) begin
            finish     = 1'b1;
            fin_status = tlif_pkg::ST_FULL;
          end
        end else if ((in_byte == tlif_pkg::B_DEL) && (char_count_r != '0)) begin
          char_count_nxt = char_count_r - 1'b1;
          res.echo_kind  = tlif_pkg::ECHO_ERASE;
        end else if (in_byte == tlif_pkg::B_KILL) begin
          char_count_nxt = '0;
          res.echo_kind  = tlif_pkg::ECHO_CLEAR;
        end else if (in_byte == tlif_pkg::B_IAC) begin
          if (iac_count_r < 2'd2) begin
            iac_count_nxt = iac_count_r + 1'b1;
          end
          phase_nxt = tlif_pkg::PH_IAC;
        end else if (in_byte == tlif_pkg::B_CR) begin
          phase_nxt = tlif_pkg::PH_AFTER_CR;
        end else if ((in_byte == tlif_pkg::B_LF) || (in_byte == tlif_pkg::B_NUL)) begin
          finish     = 1'b1;
          fin_status = tlif_pkg::ST_TERM;
        end else begin
          finish     = 1'b1;
          fin_status = tlif_pkg::ST_REJECT;
        end
      end
      default: begin
        phase_nxt = tlif_pkg::PH_NORMAL;
      end
    endcase

    // line completion: report and restart
    if (finish) begin
      len8             = 8'(char_count_nxt);
      res.done_res     = 1'b1;
      res.status       = fin_status;
      res.final_length = (fin_status == tlif_pkg::ST_REJECT) ?
                         '0 : len8[tlif_pkg::LEN_W-1:0];
      res.bot_suspect  = mode.min_iac_check && (iac_count_r < 2'd2) && !mode.known_bot;
      phase_nxt        = tlif_pkg::PH_NORMAL;
      char_count_nxt   = '0;
      iac_count_nxt    = '0;
    end
  end

  // line state advances once per transfer into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tlif_pkg::PH_NORMAL;
      char_count_r <= '0;
      iac_count_r  <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      char_count_r <= char_count_nxt;
      iac_count_r  <= iac_count_nxt;
    end
  end

  // phase register stays one-hot
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register not one-hot");

  // iac count saturates at two
  a_iac_sat: assert property (@(posedge clk) disable iff (!rst_n)
    iac_count_r != 2'd3)
    else $error("iac count past saturation");

  // length never exceeds the buffer
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_count_r <= CNT_W'(MAX_LINE))
    else $error("line length beyond buffer size");

  // a completed line restarts from a clean state
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done_res |=>
      (char_count_r == '0) && (iac_count_r == '0) && (phase_r == tlif_pkg::PH_NORMAL))
    else $error("line state not cleared after completion");

  // a stored character grows the line by one unless it completes it
  a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.store_valid && !res.done_res |=>
      char_count_r == CNT_W'($past(char_count_r) + 1'b1))
    else $error("store did not advance the line length");

endmodule

`default_nettype wire

// ===== design/telnet_line_input_filter_unit.sv =====
`default_nettype none

// path: a byte held in the input register is decoded into the result register on out_*
// throughput: one byte per cycle while out_stall is low; set by the single decode
//   step between the input register and the result register, which both hold on a stall
// reset: synchronous active-low rst_n empties both registers, returns the line
//   to the normal phase with no characters, and loads the register defaults

module telnet_line_input_filter_unit #(
  parameter int MAX_LINE = tlif_pkg::MAX_LINE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // byte input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tlif_pkg::BYTE_W-1:0]        in_byte,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [tlif_pkg::ECHO_W-1:0]             out_echo_kind,
  output logic                                    out_store_valid,
  output logic [tlif_pkg::INDEX_W-1:0]            out_store_index,
  output logic [tlif_pkg::BYTE_W-1:0]             out_store_char,
  output logic                                    out_done_res,
  output logic [tlif_pkg::STATUS_W-1:0]           out_status,
  output logic [tlif_pkg::LEN_W-1:0]              out_final_length,
  output logic                                    out_bot_suspect,
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tlif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tlif_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_LINE + 1);

  logic                          in_v_r;
  logic                          in_v_nxt;
  logic [tlif_pkg::BYTE_W-1:0]   in_byte_r;
  logic                          out_v_r;
  logic                          out_v_nxt;
  tlif_pkg::res_t                out_res_r;
  tlif_pkg::res_t                core_res;
  tlif_pkg::mode_t               mode;
  logic [CNT_W-1:0]              cap;
  logic                          in_xfer;
  logic                          adv;

  // configuration registers
  assign cfg_ready = 1'b1;

  tlif_cfg #(
    .MAX_LINE (MAX_LINE)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .mode     (mode),
    .cap      (cap)
  );

  // pipeline handshake: the held byte moves on when the result slot frees up
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign in_v_nxt  = (in_v_r && !adv) || in_xfer;
  assign out_v_nxt = adv || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_byte;
    end
    if (adv) begin
      out_res_r <= core_res;
    end
  end

  // line editing decode and state
  tlif_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .in_byte (in_byte_r),
    .mode    (mode),
    .cap     (cap),
    .res     (core_res)
  );

  // result ports
  assign out_valid        = out_v_r;
  assign out_echo_kind    = out_res_r.echo_kind;
  assign out_store_valid  = out_res_r.store_valid;
  assign out_store_index  = out_res_r.store_index;
  assign out_store_char   = out_res_r.store_char;
  assign out_done_res     = out_res_r.done_res;
  assign out_status       = out_res_r.status;
  assign out_final_length = out_res_r.final_length;
  assign out_bot_suspect  = out_res_r.bot_suspect;

  // a stall to the input only ever comes from a full, stalled result slot
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall))
    else $error("input stalled without a blocked result");

  // a stalled result slot keeps its contents
  a_hold_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_res_r))
    else $error("result changed while stalled");

  // a byte held in the input register is never dropped
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_byte_r))
    else $error("held input byte lost");

endmodule

`default_nettype wire
